[hdl/plist_pkg.sv]
// Shared types, constants and control structures for the positional list core.
package plist_pkg;

    localparam int CAPACITY  = 64;
    localparam int VAL_W     = 32;
    localparam int OP_W      = 3;
    localparam int POS_W     = 7;
    localparam int ST_W      = 3;
    localparam int CNT_OUT_W = 7;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int K_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LEVELS    = $clog2(CAPACITY);
    localparam int FOLD_N    = 1 << LEVELS;
    localparam int STEP_W    = $clog2(LEVELS + 1);
    localparam int IN_BITS   = OP_W + POS_W + VAL_W;
    localparam int OUT_BITS  = VAL_W + ST_W + CNT_OUT_W;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_BACK  = 3'd4,
        OP_DEL_AT    = 3'd5,
        OP_DEL_VALUE = 3'd6,
        OP_READ      = 3'd7
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_LOADF,
        S_FOLD,
        S_APPLY
    } state_t;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_LOAD,
        CM_SCAN,
        CM_APPLY
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t        mode;
        logic              by_value;
        logic              shift_up;
        logic              shift_dn;
        logic [K_W-1:0]    k;
        logic [K_W-1:0]    cnt;
        logic [VAL_W-1:0]  val;
    } cell_ctl_t;

endpackage

[hdl/plist_cell.sv]
// One list cell: holds an entry and its position mark, shifts with its neighbors.
module plist_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  plist_pkg::cell_ctl_t              ctl,
    input  logic [plist_pkg::K_W-1:0]         idx,
    input  logic                              mark_prev,
    input  logic                              mark_far,
    input  logic [plist_pkg::VAL_W-1:0]       v_prev,
    input  logic [plist_pkg::VAL_W-1:0]       v_nxt,
    output logic                              mark,
    output logic [plist_pkg::VAL_W-1:0]       v,
    output logic [plist_pkg::VAL_W-1:0]       sel_v
);

    logic                          mark_reg;
    logic                          mark_next;
    logic [plist_pkg::VAL_W-1:0]   v_reg;
    logic [plist_pkg::VAL_W-1:0]   v_next;

    always_comb
    begin
        mark_next = mark_reg;
        v_next    = v_reg;
        unique case (ctl.mode)
            plist_pkg::CM_LOAD:
            begin
                if (ctl.by_value)
                begin
                    mark_next = (v_reg == ctl.val) && (idx < ctl.cnt);
                end
                else
                begin
                    mark_next = (idx >= ctl.k);
                end
            end
            plist_pkg::CM_SCAN:
            begin
                mark_next = mark_reg | mark_far;
            end
            plist_pkg::CM_APPLY:
            begin
                if (ctl.shift_up && mark_reg)
                begin
                    v_next = mark_prev ? v_prev : ctl.val;
                end
                else if (ctl.shift_dn && mark_reg)
                begin
                    v_next = v_nxt;
                end
            end
            default:
            begin
                mark_next = mark_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= 1'b0;
        end
        else
        begin
            mark_reg <= mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
    end

    assign mark  = mark_reg;
    assign v     = v_reg;
    assign sel_v = (mark_reg && !mark_prev) ? v_reg : '0;

endmodule

[hdl/plist_fold.sv]
// Registered OR reduction that folds the selected cell values into one word.
module plist_fold (
    input  logic                          clk,
    input  logic                          load,
    input  logic [plist_pkg::VAL_W-1:0]   din [plist_pkg::CAPACITY],
    output logic [plist_pkg::VAL_W-1:0]   dout
);

    logic [plist_pkg::VAL_W-1:0] node_reg  [plist_pkg::FOLD_N];
    logic [plist_pkg::VAL_W-1:0] node_next [plist_pkg::FOLD_N];

    always_comb
    begin
        for (int j = 0; j < plist_pkg::FOLD_N; j++)
        begin
            if (load)
            begin
                node_next[j] = (j < plist_pkg::CAPACITY) ? din[j] : '0;
            end
            else if (j < plist_pkg::FOLD_N / 2)
            begin
                node_next[j] = node_reg[2 * j] | node_reg[2 * j + 1];
            end
            else
            begin
                node_next[j] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < plist_pkg::FOLD_N; j++)
        begin
            node_reg[j] <= node_next[j];
        end
    end

    assign dout = node_reg[0];

endmodule

[hdl/positional_list_insert_delete_core.sv]
// A request passes through the load, mark scan, fold load, value fold and apply states,
// all of them for every request, and is only then followed by the next; the apply state
// waits while the previous result is not yet taken, and the result is registered.
// Reset: asynchronous, active low; clears the entry count, marks and handshakes.
// Entry storage is not cleared; only entries below the count are ever read.
// Top level of the positional list core: control sequencer and the chain of cells.
module positional_list_insert_delete_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [plist_pkg::IN_W-1:0]    s_tdata,   // op[2:0], position[9:3], value[41:10]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [plist_pkg::OUT_W-1:0]   m_tdata    // result_value[31:0], status[34:32], count[41:35]
);

    plist_pkg::state_t                  state_reg, state_next;
    logic [plist_pkg::STEP_W-1:0]       step_reg, step_next;
    plist_pkg::op_t                     op_reg, op_next;
    logic [plist_pkg::VAL_W-1:0]        val_reg, val_next;
    logic [plist_pkg::K_W-1:0]          k_reg, k_next;
    plist_pkg::status_t                 status_reg, status_next;
    logic [plist_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                               m_valid_reg, m_valid_next;
    logic [plist_pkg::VAL_W-1:0]        res_reg, res_next;
    plist_pkg::status_t                 ost_reg, ost_next;
    logic [plist_pkg::CNT_OUT_W-1:0]    ocnt_reg, ocnt_next;

    plist_pkg::op_t                     in_op;
    logic [plist_pkg::K_W-1:0]          in_pos;
    logic [plist_pkg::K_W-1:0]          cnt_k;
    plist_pkg::status_t                 pre_status;
    logic [plist_pkg::K_W-1:0]          pre_k;
    logic                               is_ins, is_del, apply_go, fold_load;

    plist_pkg::cell_ctl_t               ctl;
    logic [plist_pkg::CAPACITY-1:0]     mark_vec;
    logic [plist_pkg::VAL_W-1:0]        v_arr   [plist_pkg::CAPACITY];
    logic [plist_pkg::VAL_W-1:0]        sel_arr [plist_pkg::CAPACITY];
    logic [plist_pkg::VAL_W-1:0]        fold_out;

    assign in_op  = plist_pkg::op_t'(s_tdata[2:0]);
    assign in_pos = plist_pkg::K_W'(s_tdata[9:3]);
    assign cnt_k  = plist_pkg::K_W'(count_reg);

    always_comb
    begin
        pre_status = plist_pkg::ST_OK;
        pre_k      = '0;
        unique case (in_op)
            plist_pkg::OP_INS_FRONT:
            begin
                if (count_reg == plist_pkg::CNT_W'(plist_pkg::CAPACITY))
                    pre_status = plist_pkg::ST_FULL;
            end
            plist_pkg::OP_INS_BACK:
            begin
                pre_k = cnt_k;
                if (count_reg == plist_pkg::CNT_W'(plist_pkg::CAPACITY))
                    pre_status = plist_pkg::ST_FULL;
            end
            plist_pkg::OP_INS_AT:
            begin
                pre_k = in_pos;
                if (count_reg == plist_pkg::CNT_W'(plist_pkg::CAPACITY))
                    pre_status = plist_pkg::ST_FULL;
                else if (in_pos > cnt_k)
                    pre_status = plist_pkg::ST_BADPOS;
            end
            plist_pkg::OP_DEL_FRONT, plist_pkg::OP_DEL_VALUE:
            begin
                if (count_reg == '0)
                    pre_status = plist_pkg::ST_EMPTY;
            end
            plist_pkg::OP_DEL_BACK:
            begin
                pre_k = cnt_k - 1'b1;
                if (count_reg == '0)
                    pre_status = plist_pkg::ST_EMPTY;
            end
            plist_pkg::OP_DEL_AT, plist_pkg::OP_READ:
            begin
                pre_k = in_pos;
                if (count_reg == '0)
                    pre_status = plist_pkg::ST_EMPTY;
                else if (in_pos >= cnt_k)
                    pre_status = plist_pkg::ST_BADPOS;
            end
            default:
            begin
                pre_status = plist_pkg::ST_OK;
            end
        endcase
    end

    assign is_ins   = (op_reg inside {plist_pkg::OP_INS_FRONT, plist_pkg::OP_INS_BACK,
                                      plist_pkg::OP_INS_AT});
    assign is_del   = (op_reg inside {plist_pkg::OP_DEL_FRONT, plist_pkg::OP_DEL_BACK,
                                      plist_pkg::OP_DEL_AT, plist_pkg::OP_DEL_VALUE});
    assign apply_go = (state_reg == plist_pkg::S_APPLY) && (!m_valid_reg || m_tready);

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        k_next       = k_reg;
        status_next  = status_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_tready;
        res_next     = res_reg;
        ost_next     = ost_reg;
        ocnt_next    = ocnt_reg;
        fold_load    = 1'b0;
        s_tready     = 1'b0;

        ctl.mode     = plist_pkg::CM_HOLD;
        ctl.by_value = (op_reg == plist_pkg::OP_DEL_VALUE);
        ctl.shift_up = is_ins && (status_reg == plist_pkg::ST_OK);
        ctl.shift_dn = is_del && (status_reg == plist_pkg::ST_OK);
        ctl.k        = k_reg;
        ctl.cnt      = cnt_k;
        ctl.val      = val_reg;

        unique case (state_reg)
            plist_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next     = in_op;
                    val_next    = s_tdata[41:10];
                    k_next      = pre_k;
                    status_next = pre_status;
                    state_next  = plist_pkg::S_LOAD;
                end
            end
            plist_pkg::S_LOAD:
            begin
                ctl.mode   = plist_pkg::CM_LOAD;
                step_next  = '0;
                state_next = plist_pkg::S_SCAN;
            end
            plist_pkg::S_SCAN:
            begin
                ctl.mode  = plist_pkg::CM_SCAN;
                step_next = step_reg + 1'b1;
                if (step_reg == plist_pkg::STEP_W'(plist_pkg::LEVELS - 1))
                    state_next = plist_pkg::S_LOADF;
            end
            plist_pkg::S_LOADF:
            begin
                fold_load = 1'b1;
                step_next = '0;
                if (op_reg == plist_pkg::OP_DEL_VALUE && status_reg == plist_pkg::ST_OK
                    && !mark_vec[plist_pkg::CAPACITY-1])
                    status_next = plist_pkg::ST_NOTFOUND;
                state_next = plist_pkg::S_FOLD;
            end
            plist_pkg::S_FOLD:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == plist_pkg::STEP_W'(plist_pkg::LEVELS - 1))
                    state_next = plist_pkg::S_APPLY;
            end
            plist_pkg::S_APPLY:
            begin
                if (apply_go)
                begin
                    ctl.mode = plist_pkg::CM_APPLY;
                    if (ctl.shift_up)
                        count_next = count_reg + 1'b1;
                    else if (ctl.shift_dn)
                        count_next = count_reg - 1'b1;
                    m_valid_next = 1'b1;
                    res_next     = ((status_reg == plist_pkg::ST_OK)
                                    && (is_del || op_reg == plist_pkg::OP_READ))
                                   ? fold_out : '0;
                    ost_next     = status_reg;
                    ocnt_next    = plist_pkg::CNT_OUT_W'(count_next);
                    state_next   = plist_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = plist_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= plist_pkg::S_IDLE;
            step_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            status_reg  <= plist_pkg::ST_OK;
            op_reg      <= plist_pkg::OP_READ;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            status_reg  <= status_next;
            op_reg      <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        k_reg    <= k_next;
        res_reg  <= res_next;
        ost_reg  <= ost_next;
        ocnt_reg <= ocnt_next;
    end

    for (genvar i = 0; i < plist_pkg::CAPACITY; i++)
    begin : g_cell
        logic                          mp;
        logic                          far;
        logic [plist_pkg::VAL_W-1:0]   vp;
        logic [plist_pkg::VAL_W-1:0]   vn;

        if (i == 0)
        begin : g_first
            assign mp = 1'b0;
            assign vp = val_reg;
        end
        else
        begin : g_inner
            assign mp = mark_vec[i-1];
            assign vp = v_arr[i-1];
        end

        if (i == plist_pkg::CAPACITY - 1)
        begin : g_last
            assign vn = v_arr[i];
        end
        else
        begin : g_body
            assign vn = v_arr[i+1];
        end

        always_comb
        begin
            far = 1'b0;
            for (int s = 0; s < plist_pkg::LEVELS; s++)
            begin
                if (step_reg == plist_pkg::STEP_W'(s) && i >= (1 << s))
                    far = mark_vec[(i >= (1 << s)) ? i - (1 << s) : 0];
            end
        end

        plist_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .idx       (plist_pkg::K_W'(i)),
            .mark_prev (mp),
            .mark_far  (far),
            .v_prev    (vp),
            .v_nxt     (vn),
            .mark      (mark_vec[i]),
            .v         (v_arr[i]),
            .sel_v     (sel_arr[i])
        );
    end

    plist_fold u_fold (
        .clk  (clk),
        .load (fold_load),
        .din  (sel_arr),
        .dout (fold_out)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = plist_pkg::OUT_W'({ocnt_reg, ost_reg, res_reg});

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= plist_pkg::CNT_W'(plist_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (apply_go && is_ins && status_reg == plist_pkg::ST_OK)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not advance count");

    a_single_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plist_pkg::S_LOADF)
        |-> $onehot0(mark_vec & ~{mark_vec[plist_pkg::CAPACITY-2:0], 1'b0}))
        else $error("mark vector not prefix closed");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && ost_reg != plist_pkg::ST_OK) |-> res_reg == '0)
        else $error("failed request returned data");
`endif

endmodule

[tb/tb_positional_list_insert_delete_core.sv]
// Self-checking testbench for the positional list insert/delete core.
module tb_positional_list_insert_delete_core;

    localparam int RANDOM_ITEMS = 1575;
    localparam int DRAIN_CYCLES = 2 * plist_pkg::LEVELS + 8;

    typedef struct {
        plist_pkg::op_t                op;
        logic [plist_pkg::POS_W-1:0]   pos;
        logic [plist_pkg::VAL_W-1:0]   val;
    } request_t;

    typedef struct packed {
        logic [plist_pkg::VAL_W-1:0]     value;
        plist_pkg::status_t              status;
        logic [plist_pkg::CNT_OUT_W-1:0] count;
    } list_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [plist_pkg::IN_W-1:0]     s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [plist_pkg::OUT_W-1:0]    m_tdata;

    request_t                       request_queue[$];
    list_result_t                   pending_results[$];
    logic [plist_pkg::VAL_W-1:0]    list_model[$];
    logic [plist_pkg::VAL_W-1:0]    value_pool[8];
    logic [plist_pkg::VAL_W-1:0]    extreme_values[4] = '{32'h8000_0000, 32'h7FFF_FFFF,
                                                          32'h0, 32'hFFFF_FFFF};
    int                             planned_count = 0;
    int unsigned                    gap_left = 0;
    int unsigned                    stall_left = 0;
    logic [15:0]                    cyc = '0;
    int                             errors = 0;
    int                             requests_seen = 0;
    int                             results_seen = 0;
    int                             status_hits[5] = '{0, 0, 0, 0, 0};
    list_result_t                   got;
    list_result_t                   want;

    wire quiet = (cyc[10:9] == 2'b11);

    positional_list_insert_delete_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned draw_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 48);
    endfunction

    function automatic list_result_t list_apply(input plist_pkg::op_t op,
                                                input logic [plist_pkg::POS_W-1:0] pos,
                                                input logic [plist_pkg::VAL_W-1:0] v);
        list_result_t r;
        int           cnt;
        int           idx;
        bit           hit;
        r.value  = '0;
        r.status = plist_pkg::ST_OK;
        cnt      = list_model.size();
        idx      = 0;
        hit      = 1'b0;
        case (op)
            plist_pkg::OP_INS_FRONT:
                if (cnt >= plist_pkg::CAPACITY) r.status = plist_pkg::ST_FULL;
                else list_model.push_front(v);
            plist_pkg::OP_INS_BACK:
                if (cnt >= plist_pkg::CAPACITY) r.status = plist_pkg::ST_FULL;
                else list_model.push_back(v);
            plist_pkg::OP_INS_AT:
                if (cnt >= plist_pkg::CAPACITY) r.status = plist_pkg::ST_FULL;
                else if (pos > cnt) r.status = plist_pkg::ST_BADPOS;
                else list_model.insert(pos, v);
            plist_pkg::OP_DEL_FRONT:
                if (cnt == 0) r.status = plist_pkg::ST_EMPTY;
                else r.value = list_model.pop_front();
            plist_pkg::OP_DEL_BACK:
                if (cnt == 0) r.status = plist_pkg::ST_EMPTY;
                else r.value = list_model.pop_back();
            plist_pkg::OP_DEL_AT:
                if (cnt == 0) r.status = plist_pkg::ST_EMPTY;
                else if (pos >= cnt) r.status = plist_pkg::ST_BADPOS;
                else
                begin
                    r.value = list_model[pos];
                    list_model.delete(pos);
                end
            plist_pkg::OP_DEL_VALUE:
                if (cnt == 0) r.status = plist_pkg::ST_EMPTY;
                else
                begin
                    for (int i = 0; i < cnt; i++)
                        if (!hit && list_model[i] == v)
                        begin
                            hit = 1'b1;
                            idx = i;
                        end
                    if (hit)
                    begin
                        r.value = list_model[idx];
                        list_model.delete(idx);
                    end
                    else
                        r.status = plist_pkg::ST_NOTFOUND;
                end
            default:
                if (cnt == 0) r.status = plist_pkg::ST_EMPTY;
                else if (pos >= cnt) r.status = plist_pkg::ST_BADPOS;
                else r.value = list_model[pos];
        endcase
        r.count = plist_pkg::CNT_OUT_W'(list_model.size());
        return r;
    endfunction

    // track the planned count only roughly, to steer positions toward valid ones
    task automatic add_request(input plist_pkg::op_t op,
                               input logic [plist_pkg::POS_W-1:0] pos,
                               input logic [plist_pkg::VAL_W-1:0] v);
        request_t rq;
        bit       pooled;
        rq.op  = op;
        rq.pos = pos;
        rq.val = v;
        request_queue.push_back(rq);
        pooled = 1'b0;
        foreach (value_pool[k])
            if (value_pool[k] == v)
                pooled = 1'b1;
        case (op)
            plist_pkg::OP_INS_FRONT, plist_pkg::OP_INS_BACK:
                if (planned_count < plist_pkg::CAPACITY) planned_count++;
            plist_pkg::OP_INS_AT:
                if (planned_count < plist_pkg::CAPACITY && pos <= planned_count)
                    planned_count++;
            plist_pkg::OP_DEL_FRONT, plist_pkg::OP_DEL_BACK:
                if (planned_count > 0) planned_count--;
            plist_pkg::OP_DEL_AT:
                if (planned_count > 0 && pos < planned_count) planned_count--;
            plist_pkg::OP_DEL_VALUE:
                if (planned_count > 0 && pooled) planned_count--;
            default:
                ;
        endcase
    endtask

    initial
    begin : stimulus
        int unsigned                    n;
        int unsigned                    phase_len;
        int unsigned                    kind;
        int unsigned                    r;
        plist_pkg::op_t                 op;
        logic [plist_pkg::POS_W-1:0]    pos;
        logic [plist_pkg::VAL_W-1:0]    v;
        foreach (value_pool[k])
            value_pool[k] = $urandom;

        add_request(plist_pkg::OP_DEL_FRONT, 7'd0, 32'h0);
        add_request(plist_pkg::OP_DEL_BACK, 7'd0, 32'h0);
        add_request(plist_pkg::OP_DEL_AT, 7'd0, 32'h0);
        add_request(plist_pkg::OP_DEL_VALUE, 7'd0, 32'h0);
        add_request(plist_pkg::OP_READ, 7'd0, 32'h0);
        add_request(plist_pkg::OP_INS_AT, 7'd1, 32'h1);
        add_request(plist_pkg::OP_INS_AT, 7'd0, 32'h8000_0000);
        add_request(plist_pkg::OP_INS_FRONT, 7'd0, 32'h7FFF_FFFF);
        add_request(plist_pkg::OP_INS_BACK, 7'd0, 32'hFFFF_FFFF);
        add_request(plist_pkg::OP_INS_AT, 7'd3, 32'h0);
        add_request(plist_pkg::OP_INS_AT, 7'd127, 32'h5);
        add_request(plist_pkg::OP_INS_AT, 7'd64, 32'h6);
        for (int k = 0; k < 4; k++)
            add_request(plist_pkg::OP_READ, plist_pkg::POS_W'(k), 32'h0);
        add_request(plist_pkg::OP_READ, 7'd4, 32'h0);
        add_request(plist_pkg::OP_READ, 7'd127, 32'h0);
        add_request(plist_pkg::OP_DEL_AT, 7'd4, 32'h0);
        add_request(plist_pkg::OP_DEL_VALUE, 7'd0, 32'h1234_5678);
        add_request(plist_pkg::OP_INS_AT, 7'd1, 32'hFFFF_FFFF);
        add_request(plist_pkg::OP_DEL_VALUE, 7'd0, 32'hFFFF_FFFF);
        add_request(plist_pkg::OP_DEL_AT, 7'd1, 32'h0);
        add_request(plist_pkg::OP_DEL_BACK, 7'd0, 32'h0);
        add_request(plist_pkg::OP_DEL_FRONT, 7'd0, 32'h0);
        add_request(plist_pkg::OP_DEL_FRONT, 7'd0, 32'h0);

        // rotate through fill, mixed and drain phases
        n    = 0;
        kind = 0;
        while (n < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(60, 140);
            if (phase_len > RANDOM_ITEMS - n)
                phase_len = RANDOM_ITEMS - n;
            repeat (phase_len)
            begin
                if ($urandom_range(0, 99) < 8)
                begin
                    op  = plist_pkg::op_t'($urandom_range(0, 7));
                    pos = plist_pkg::POS_W'($urandom_range(0, 127));
                    v   = $urandom;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    case (kind)
                        0:       op = (r < 88) ? plist_pkg::op_t'($urandom_range(0, 2))
                                               : plist_pkg::op_t'($urandom_range(3, 7));
                        1:       op = plist_pkg::op_t'($urandom_range(0, 7));
                        default: op = (r < 75) ? plist_pkg::op_t'($urandom_range(3, 6))
                                    : (r < 88) ? plist_pkg::OP_READ
                                               : plist_pkg::op_t'($urandom_range(0, 2));
                    endcase
                    if ($urandom_range(0, 99) < 12)
                        pos = plist_pkg::POS_W'($urandom_range(0, 127));
                    else if (op == plist_pkg::OP_INS_AT)
                        pos = plist_pkg::POS_W'($urandom_range(0, planned_count));
                    else
                        pos = (planned_count == 0)
                              ? '0
                              : plist_pkg::POS_W'($urandom_range(0, planned_count - 1));
                    r = $urandom_range(0, 99);
                    if (r < 45)
                        v = value_pool[$urandom_range(0, 7)];
                    else if (r < 55)
                        v = extreme_values[$urandom_range(0, 3)];
                    else
                        v = $urandom;
                end
                add_request(op, pos, v);
                n++;
            end
            kind = (kind + 1) % 3;
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || s_tvalid)
            @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d requests and %0d results; ok %0d, full %0d, empty %0d,",
                 requests_seen, results_seen, status_hits[plist_pkg::ST_OK],
                 status_hits[plist_pkg::ST_FULL], status_hits[plist_pkg::ST_EMPTY]);
        $display("bad position %0d, value not found %0d; %0d mismatches.",
                 status_hits[plist_pkg::ST_BADPOS], status_hits[plist_pkg::ST_NOTFOUND],
                 errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left != 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (request_queue.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {{(plist_pkg::IN_W - plist_pkg::IN_BITS){1'b0}},
                             request_queue[0].val, request_queue[0].pos,
                             request_queue[0].op};
                gap_left <= quiet ? 0 : draw_pause();
                void'(request_queue.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1'b1;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready   <= 1'b1;
            stall_left <= quiet ? 0 : draw_pause();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                pending_results.push_back(list_apply(
                    plist_pkg::op_t'(s_tdata[plist_pkg::OP_W-1:0]),
                    s_tdata[plist_pkg::OP_W +: plist_pkg::POS_W],
                    s_tdata[plist_pkg::OP_W + plist_pkg::POS_W +: plist_pkg::VAL_W]));
                requests_seen++;
            end
            if (m_tvalid && m_tready)
            begin
                got.value  = m_tdata[plist_pkg::VAL_W-1:0];
                got.status = plist_pkg::status_t'(m_tdata[plist_pkg::VAL_W +: plist_pkg::ST_W]);
                got.count  = m_tdata[plist_pkg::VAL_W + plist_pkg::ST_W +: plist_pkg::CNT_OUT_W];
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction: value %h status %0d count %0d",
                             $time, got.value, got.status, got.count);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (want.status <= plist_pkg::ST_NOTFOUND)
                        status_hits[want.status]++;
                    if (got.value !== want.value || got.status !== want.status ||
                        got.count !== want.count)
                    begin
                        errors++;
                        $display("%0t: mismatch: expected value %h status %0d count %0d, %s",
                                 $time, want.value, want.status, want.count,
                                 $sformatf("actual value %h status %0d count %0d",
                                           got.value, got.status, got.count));
                    end
                end
            end
        end
    end

endmodule

[filelist.f]
hdl/plist_pkg.sv
hdl/plist_cell.sv
hdl/plist_fold.sv
hdl/positional_list_insert_delete_core.sv
tb/tb_positional_list_insert_delete_core.sv
